FILE: rtl/assert_macros.svh
// Assertion macros shared by checker files.
// Include-guarded; holds macro definitions only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, disabled while in reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`endif

FILE: rtl/arxprg_pkg.sv
`timescale 1ns / 1ps
// Package for the ARX pool random generator.
// Holds action codes, pool reset constants and channel payload types.
package arxprg_pkg;

  localparam int unsigned PoolWords = 20;

  typedef enum logic [2:0] {
    ACT_SEED  = 3'd0,
    ACT_RAW   = 3'd1,
    ACT_BOUND = 3'd2,
    ACT_RANGE = 3'd3,
    ACT_FILL  = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [63:0]        seed_value;
    logic               overwrite;
    logic [31:0]        bound;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [6:0]         block_bytes;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } out_item_t;

  localparam logic [63:0] SmGamma = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SmMul1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SmMul2  = 64'h94d049bb133111eb;

  function automatic logic [31:0] pool_reset(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h243f6a88;
      5'd1:  r = 32'h85a308d3;
      5'd2:  r = 32'h13198a2e;
      5'd3:  r = 32'h03707344;
      5'd4:  r = 32'ha4093822;
      5'd5:  r = 32'h299f31d0;
      5'd6:  r = 32'h082efa98;
      5'd7:  r = 32'hec4e6c89;
      5'd8:  r = 32'h452821e6;
      5'd9:  r = 32'h38d01377;
      5'd10: r = 32'hbe5466cf;
      5'd11: r = 32'h34e90c6c;
      5'd12: r = 32'hc0ac29b7;
      5'd13: r = 32'hc97c50dd;
      5'd14: r = 32'h3f84d5b5;
      5'd15: r = 32'hb5470917;
      5'd16: r = 32'h9216d5d9;
      5'd17: r = 32'h8979fb1b;
      5'd18: r = 32'hd1310ba6;
      5'd19: r = 32'h98dfb5ac;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

FILE: rtl/arxprg_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interface carrying one payload type.
// Used for the input and result channels of the generator.
interface arxprg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/arxprg_qr_unit.sv
`timescale 1ns / 1ps
// Shared ChaCha quarter-round unit: one half quarter round per call.
// Depends on arxprg_pkg for the rotate helper.
module arxprg_qr_unit (
  input  logic        half_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);
  import arxprg_pkg::*;

  logic [31:0] a1, d1, c1;

  always_comb begin
    a1  = a_i + b_i;
    d1  = half_i ? rotl(d_i ^ a1, 8) : rotl(d_i ^ a1, 16);
    c1  = c_i + d1;
    a_o = a1;
    d_o = d1;
    c_o = c1;
    b_o = half_i ? rotl(b_i ^ c1, 7) : rotl(b_i ^ c1, 12);
  end
endmodule

FILE: rtl/arx_pool_random_generator_unit.sv
`timescale 1ns / 1ps
// ARX pool random generator. One tick: stir, word 19 update, 16 half quarter rounds on
// the shared quarter-round unit, and fold. Raw draw and fill: one tick after accept,
// fill then one word per cycle while the output is not stalled. Modulo draws add a
// restoring divider. Bound zero or empty range: answered without a tick. Seeding: 20
// words x 9 steps on a shared 32x32 multiplier + 4 ticks. One transaction at a time.
// Asynchronous active-low reset restores the constant pool, clears counter and seeded flag.
module arx_pool_random_generator_unit (
  input  logic clk_i,
  input  logic rst_ni,
  arxprg_stream_if.sink   in_if,
  arxprg_stream_if.source out_if
);
  import arxprg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SEED, S_STIR, S_QR, S_FOLD, S_DIV, S_EMIT
  } state_e;

  state_e      state_q;
  logic [31:0] pool_q [PoolWords];
  logic [31:0] tick_q;
  logic        seeded_q;
  in_item_t    item_q;
  logic [3:0]  qr_q;
  logic        half_q;
  logic [2:0]  ticks_q;
  logic [4:0]  sidx_q;
  logic [3:0]  sstep_q;
  logic [63:0] s_q, x_q, acc_q;
  logic [31:0] rem_q, quo_q, div_q;
  logic [5:0]  dcnt_q;
  logic [3:0]  emit_q, nwords_q;
  logic        ov_q;
  logic [31:0] ow_q;
  logic        ol_q;

  logic [4:0]  ia, ib, ic, id;
  logic [31:0] qa, qb, qc, qd;
  logic [32:0] rsh;
  logic [31:0] raw, span;
  logic [63:0] s_nx, mul_k, mul_p;
  logic [31:0] mul_a, mul_b;
  logic [6:0]  bsat;

  always_comb begin
    unique case (qr_q[2:0])
      3'd0: begin ia = 5'd0; ib = 5'd4; ic = 5'd8;  id = 5'd12; end
      3'd1: begin ia = 5'd1; ib = 5'd5; ic = 5'd9;  id = 5'd13; end
      3'd2: begin ia = 5'd2; ib = 5'd6; ic = 5'd10; id = 5'd14; end
      3'd3: begin ia = 5'd3; ib = 5'd7; ic = 5'd11; id = 5'd15; end
      3'd4: begin ia = 5'd0; ib = 5'd5; ic = 5'd10; id = 5'd15; end
      3'd5: begin ia = 5'd1; ib = 5'd6; ic = 5'd11; id = 5'd12; end
      3'd6: begin ia = 5'd2; ib = 5'd7; ic = 5'd8;  id = 5'd13; end
      default: begin ia = 5'd3; ib = 5'd4; ic = 5'd9; id = 5'd14; end
    endcase
  end

  arxprg_qr_unit u_qr (
    .half_i(half_q),
    .a_i(pool_q[ia]), .b_i(pool_q[ib]), .c_i(pool_q[ic]), .d_i(pool_q[id]),
    .a_o(qa), .b_o(qb), .c_o(qc), .d_o(qd)
  );

  assign raw  = pool_q[0] ^ pool_q[12];
  assign span = item_q.range_high - item_q.range_low;
  assign rsh  = {rem_q, quo_q[31]};
  assign bsat = (item_q.block_bytes > 7'd64) ? 7'd64 : item_q.block_bytes;

  always_comb begin
    s_nx  = s_q + SmGamma;
    mul_k = (sstep_q < 4'd4) ? SmMul1 : SmMul2;
    case (sstep_q) inside
      4'd2, 4'd6: begin mul_a = x_q[31:0];  mul_b = mul_k[63:32]; end
      4'd3, 4'd7: begin mul_a = x_q[63:32]; mul_b = mul_k[31:0];  end
      default:    begin mul_a = x_q[31:0];  mul_b = mul_k[31:0];  end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign in_if.ready = (state_q == S_IDLE) && !ov_q;
  assign out_if.valid = ov_q;
  assign out_if.data  = '{word: ow_q, last: ol_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      for (int i = 0; i < PoolWords; i++) pool_q[i] <= pool_reset(5'(i));
      tick_q   <= '0;
      seeded_q <= 1'b0;
      ov_q     <= 1'b0;
      item_q   <= '0;
      qr_q <= '0; half_q <= 1'b0; ticks_q <= '0; sidx_q <= '0; sstep_q <= '0;
      s_q <= '0; x_q <= '0; acc_q <= '0;
      rem_q <= '0; quo_q <= '0; div_q <= '0; ow_q <= '0; ol_q <= 1'b0;
      dcnt_q <= '0; emit_q <= '0; nwords_q <= '0;
    end else begin
      if (ov_q && out_if.ready && state_q != S_EMIT) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_if.valid && in_if.ready) begin
          item_q <= in_if.data;
          ticks_q <= 3'd1;
          unique case (in_if.data.action)
            ACT_SEED: if (in_if.data.overwrite || !seeded_q) begin
              s_q <= in_if.data.seed_value; sidx_q <= '0; sstep_q <= '0;
              state_q <= S_SEED;
            end
            ACT_RAW: state_q <= S_STIR;
            ACT_BOUND: if (in_if.data.bound == '0) begin
              ow_q <= '0; ol_q <= 1'b1; ov_q <= 1'b1;
            end else state_q <= S_STIR;
            ACT_RANGE:
              if ((in_if.data.range_low ^ 32'h80000000) >=
                  (in_if.data.range_high ^ 32'h80000000)) begin
                ow_q <= in_if.data.range_low; ol_q <= 1'b1; ov_q <= 1'b1;
              end else state_q <= S_STIR;
            ACT_FILL: if (in_if.data.block_bytes != '0) state_q <= S_STIR;
            default: ;
          endcase
        end
        S_SEED: begin
          case (sstep_q) inside
            4'd0: begin
              s_q <= s_nx; x_q <= s_nx ^ (s_nx >> 30); sstep_q <= 4'd1;
            end
            4'd1, 4'd5: begin
              acc_q <= mul_p; sstep_q <= sstep_q + 4'd1;
            end
            4'd2, 4'd3, 4'd6, 4'd7: begin
              acc_q[63:32] <= acc_q[63:32] + mul_p[31:0]; sstep_q <= sstep_q + 4'd1;
            end
            4'd4: begin
              x_q <= acc_q ^ (acc_q >> 27); sstep_q <= 4'd5;
            end
            default: begin
              pool_q[sidx_q] <= acc_q[31:0] ^ acc_q[62:31];
              sstep_q <= 4'd0;
              if (sidx_q == 5'(PoolWords - 1)) begin
                tick_q <= '0; ticks_q <= 3'd4; state_q <= S_STIR;
              end else sidx_q <= sidx_q + 5'd1;
            end
          endcase
        end
        S_STIR: begin
          pool_q[16] <= pool_q[16] + tick_q + 32'd1;
          pool_q[17] <= pool_q[17] ^ (pool_q[16] + tick_q + 32'd1);
          pool_q[18] <= pool_q[18] + (pool_q[17] ^ (pool_q[16] + tick_q + 32'd1));
          tick_q <= tick_q + 32'd1;
          qr_q <= '0; half_q <= 1'b0;
          state_q <= S_QR;
          sidx_q <= '0;
        end
        S_QR: begin
          if (sidx_q == 5'd0) begin
            pool_q[19] <= pool_q[19] ^ rotl(pool_q[18], 13);
            sidx_q <= 5'd1;
          end else begin
            pool_q[ia] <= qa; pool_q[ib] <= qb; pool_q[ic] <= qc; pool_q[id] <= qd;
            half_q <= !half_q;
            if (half_q) begin
              if (qr_q == 4'd7) state_q <= S_FOLD;
              else qr_q <= qr_q + 4'd1;
            end
          end
        end
        S_FOLD: begin
          pool_q[0]  <= pool_q[0] ^ pool_q[16];
          pool_q[5]  <= pool_q[5] ^ pool_q[17];
          pool_q[10] <= pool_q[10] ^ pool_q[18];
          pool_q[15] <= pool_q[15] ^ pool_q[19];
          if (ticks_q != 3'd1) begin
            ticks_q <= ticks_q - 3'd1; state_q <= S_STIR;
          end else begin
            unique case (item_q.action)
              ACT_SEED: begin seeded_q <= 1'b1; state_q <= S_IDLE; end
              ACT_RAW: begin
                ow_q <= raw ^ pool_q[16];
                ol_q <= 1'b1; ov_q <= 1'b1; state_q <= S_IDLE;
              end
              ACT_FILL: begin
                emit_q <= '0; nwords_q <= 4'((bsat + 7'd3) >> 2) - 4'd1;
                state_q <= S_EMIT;
              end
              default: begin
                quo_q <= raw ^ pool_q[16];
                div_q <= (item_q.action == ACT_BOUND) ? item_q.bound : span;
                rem_q <= '0; dcnt_q <= '0; state_q <= S_DIV;
              end
            endcase
          end
        end
        S_DIV: begin
          if (dcnt_q == 6'd32) begin
            ow_q <= (item_q.action == ACT_BOUND) ? rem_q : item_q.range_low + rem_q;
            ol_q <= 1'b1; ov_q <= 1'b1; state_q <= S_IDLE;
          end else begin
            quo_q <= quo_q << 1;
            rem_q <= (rsh >= {1'b0, div_q}) ? 32'(rsh - {1'b0, div_q}) : rsh[31:0];
            dcnt_q <= dcnt_q + 6'd1;
          end
        end
        S_EMIT: if (!ov_q || out_if.ready) begin
          ow_q <= pool_q[5'(emit_q)];
          ol_q <= (emit_q == nwords_q);
          ov_q <= 1'b1;
          if (emit_q == nwords_q) state_q <= S_IDLE;
          else emit_q <= emit_q + 4'd1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/arxprg_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the generator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module arxprg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_no_take_busy, clk_i, rst_ni, out_valid |-> !in_ready)
  `ASSERT_CLK(a_last_stable, clk_i, rst_ni, out_valid && !out_ready |=> $stable(out_last))
endmodule

bind arx_pool_random_generator_unit arxprg_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_last(out_if.data.last)
);
